>>> hdl/msscan_pkg.sv
package msscan_pkg;

    localparam int PATTERN_BYTES  = 16;
    localparam int VALUE_BYTES    = 4;
    localparam int OFFSET_BITS    = 24;
    localparam int LEN_BITS       = $clog2(PATTERN_BYTES + 1);
    localparam int POS_BITS       = $clog2(PATTERN_BYTES);
    localparam int VALUE_BITS     = 8 * VALUE_BYTES;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 64;

    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LOW       = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_HIGH      = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COMPARE_MASK      = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LENGTH    = 4'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VALUE_OFFSET      = 4'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_POINTER      = 4'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_OFFSET       = 4'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SUBSTITUTE_ENABLE = 4'd7;

    typedef logic [7:0] byte_t;
    typedef byte_t [PATTERN_BYTES-1:0] window_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       block_end;
    } in_t;

    typedef struct packed {
        logic                   found;
        logic [OFFSET_BITS-1:0] match_offset;
        logic [VALUE_BITS-1:0]  found_value;
    } out_t;

    typedef struct packed {
        logic [63:0] pattern_low;
        logic [63:0] pattern_high;
        logic [15:0] compare_mask;
        logic [4:0]  pattern_length;
        logic [3:0]  value_offset;
        logic [31:0] base_pointer;
        logic [3:0]  base_offset;
        logic        substitute_enable;
    } cfg_t;

    typedef struct packed {
        logic                  hit;
        logic [LEN_BITS-1:0]   eff_len;
        logic [VALUE_BITS-1:0] value;
    } match_t;

endpackage

>>> hdl/masked_signature_scanner_unit.sv
// masked byte pattern search, one data byte per request
// a hit, or a block end without one, is reported from the result stage
// one byte per cycle unless m_ stalls; single-pass window compare
// reset: synchronous, active low; registers return to defaults, window,
// byte count and match flag clear, both pipeline stages empty
module masked_signature_scanner_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  msscan_pkg::in_t                       s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output msscan_pkg::out_t                      m_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [msscan_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [msscan_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import msscan_pkg::*;

    localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

    cfg_t                   cfg_reg;
    logic                   in_valid_reg;
    in_t                    in_data_reg;
    window_t                window_reg;
    window_t                window_next;
    logic [OFFSET_BITS-1:0] count_reg;
    logic [OFFSET_BITS-1:0] count_next;
    logic                   matched_reg;
    logic                   m_valid_reg;
    out_t                   m_data_reg;

    match_t match;
    logic   advance;
    logic   active;
    logic   hit;
    logic   miss;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{pattern_low:       '0,
                         pattern_high:      '0,
                         compare_mask:      '0,
                         pattern_length:    5'd1,
                         value_offset:      '0,
                         base_pointer:      '0,
                         base_offset:       '0,
                         substitute_enable: 1'b0};
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_PATTERN_LOW:       cfg_reg.pattern_low       <= cfg_data;
                REG_PATTERN_HIGH:      cfg_reg.pattern_high      <= cfg_data;
                REG_COMPARE_MASK:      cfg_reg.compare_mask      <= cfg_data[15:0];
                REG_PATTERN_LENGTH:    cfg_reg.pattern_length    <= cfg_data[4:0];
                REG_VALUE_OFFSET:      cfg_reg.value_offset      <= cfg_data[3:0];
                REG_BASE_POINTER:      cfg_reg.base_pointer      <= cfg_data[31:0];
                REG_BASE_OFFSET:       cfg_reg.base_offset       <= cfg_data[3:0];
                REG_SUBSTITUTE_ENABLE: cfg_reg.substitute_enable <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // input stage
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // window with the new byte shifted in
    always_comb begin
        for (int i = 0; i < PATTERN_BYTES - 1; i++) begin
            window_next[i] = window_reg[i+1];
        end
        window_next[PATTERN_BYTES-1] = in_data_reg.data_byte;
    end

    assign count_next = count_reg + OFFSET_BITS'(1);

    msscan_match u_match (
        .cfg    (cfg_reg),
        .window (window_next),
        .result (match)
    );

    assign active = !matched_reg && (count_reg != COUNT_MAX);
    assign hit    = active && (count_next >= OFFSET_BITS'(match.eff_len)) && match.hit;
    assign miss   = in_data_reg.block_end && !matched_reg && !hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg  <= '0;
            count_reg   <= '0;
            matched_reg <= 1'b0;
        end else if (advance) begin
            if (in_data_reg.block_end) begin
                window_reg  <= '0;
                count_reg   <= '0;
                matched_reg <= 1'b0;
            end else if (active) begin
                window_reg  <= window_next;
                count_reg   <= count_next;
                matched_reg <= hit;
            end
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= (advance && (hit || miss)) || (m_valid_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && (hit || miss)) begin
            m_data_reg.found <= hit;
            if (hit) begin
                m_data_reg.match_offset <= count_next - OFFSET_BITS'(match.eff_len);
                m_data_reg.found_value  <= match.value;
            end else begin
                m_data_reg.match_offset <= '0;
                m_data_reg.found_value  <= '0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> hdl/msscan_match.sv
module msscan_match (
    input  msscan_pkg::cfg_t    cfg,
    input  msscan_pkg::window_t window,
    output msscan_pkg::match_t  result
);
    import msscan_pkg::*;

    logic [LEN_BITS-1:0] len;
    logic [LEN_BITS-1:0] start;
    byte_t               pat [PATTERN_BYTES];
    logic [POS_BITS-1:0] rel [PATTERN_BYTES];
    logic [LEN_BITS-1:0] pos [VALUE_BYTES];
    logic                ok;
    logic [VALUE_BITS-1:0] value;

    // effective length, clamped to 1..PATTERN_BYTES
    always_comb begin
        if (cfg.pattern_length == '0) begin
            len = LEN_BITS'(1);
        end else if (LEN_BITS'(cfg.pattern_length) > LEN_BITS'(PATTERN_BYTES)) begin
            len = LEN_BITS'(PATTERN_BYTES);
        end else begin
            len = LEN_BITS'(cfg.pattern_length);
        end
        start = LEN_BITS'(PATTERN_BYTES) - len;
    end

    // pattern bytes with optional base pointer substitution
    always_comb begin
        for (int i = 0; i < PATTERN_BYTES; i++) begin
            rel[i] = POS_BITS'(i) - cfg.base_offset;
            if (i < 8) begin
                pat[i] = cfg.pattern_low[8*(i%8) +: 8];
            end else if (i < 16) begin
                pat[i] = cfg.pattern_high[8*(i%8) +: 8];
            end else begin
                pat[i] = '0;
            end
            if (cfg.substitute_enable &&
                (LEN_BITS'(i) >= LEN_BITS'(cfg.base_offset)) &&
                (LEN_BITS'(i) < LEN_BITS'(cfg.base_offset) + LEN_BITS'(4))) begin
                pat[i] = cfg.base_pointer[8*rel[i][1:0] +: 8];
            end
        end
    end

    always_comb begin
        ok = 1'b1;
        for (int i = 0; i < PATTERN_BYTES; i++) begin
            if ((i < 16) && (LEN_BITS'(i) < len) && cfg.compare_mask[i % 16] &&
                (window[POS_BITS'(start + LEN_BITS'(i))] != pat[i])) begin
                ok = 1'b0;
            end
        end
    end

    // extracted word, bytes past the matched pattern read as zero
    always_comb begin
        value = '0;
        for (int j = 0; j < VALUE_BYTES; j++) begin
            pos[j] = LEN_BITS'(cfg.value_offset) + LEN_BITS'(j);
            if (pos[j] < len) begin
                value[8*j +: 8] = window[POS_BITS'(start + pos[j])];
            end
        end
    end

    assign result.hit     = ok;
    assign result.eff_len = len;
    assign result.value   = value;

endmodule
